### design/srng_pkg.sv
// Shared constants and control types for the shuffled minimal-standard generator.
package srng_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned PROD_W  = 46;
  localparam int unsigned MULT_W  = 15;

  localparam logic [VALUE_W-1:0] MODULUS    = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0]  MULTIPLIER = 15'd16807;

  // extra generator steps run ahead of the table fill during warm-up
  localparam int unsigned WARMUP_EXTRA = 8;

  typedef struct packed {
    logic load_seed;  // generator <= cleaned seed
    logic mul;        // product <= generator * multiplier
    logic fold;       // generator <= product mod modulus
    logic warm_wr;    // table[warm index] <= folded value
    logic warm_last;  // last warm-up step: last output <= folded value
    logic slot_calc;  // slot <= last output / slot divisor
    logic rd;         // table read data <= table[slot]
    logic commit;     // emit read data, table[slot] <= generator
  } cmd_t;

endpackage

### design/srng_ctrl.sv
// Controller: sequences warm-up, generator steps, table access and result commit.
module srng_ctrl #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   draw_valid,
  input  logic                   draw_request,
  output logic                   draw_stall,
  input  logic                   seed_we,
  input  logic                   out_full,
  output srng_pkg::cmd_t         cmd,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] warm_idx
);

  localparam int unsigned SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned WARMUP = TABLE_SIZE + srng_pkg::WARMUP_EXTRA;
  localparam int unsigned CNT_W  = $clog2(WARMUP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_WMUL  = 3'd2;
  localparam logic [2:0] ST_WFOLD = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_FOLD  = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             warm_pending;
  logic             warm_pending_next;
  logic             accept;

  assign draw_stall = (state != ST_IDLE);
  assign accept     = draw_valid && !draw_stall;
  assign warm_idx   = idx[SLOT_W-1:0];

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    warm_pending_next = warm_pending;
    cmd               = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && draw_request) begin
          state_next = warm_pending ? ST_LOAD : ST_MUL;
        end
      end
      ST_LOAD: begin
        cmd.load_seed = 1'b1;
        idx_next      = CNT_W'(WARMUP - 1);
        state_next    = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_WFOLD;
      end
      ST_WFOLD: begin
        cmd.fold      = 1'b1;
        cmd.warm_wr   = (idx < CNT_W'(TABLE_SIZE));
        cmd.warm_last = (idx == '0);
        if (idx == '0) begin
          warm_pending_next = 1'b0;
          state_next        = ST_MUL;
        end else begin
          idx_next   = idx - CNT_W'(1);
          state_next = ST_WMUL;
        end
      end
      ST_MUL: begin
        cmd.mul       = 1'b1;
        cmd.slot_calc = 1'b1;
        state_next    = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        cmd.rd     = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!out_full) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (seed_we) begin
      warm_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      warm_pending <= 1'b1;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      warm_pending <= warm_pending_next;
    end
  end

  // warm-up only retires on its final step
  a_warm_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(warm_pending) |-> ($past(state) == ST_WFOLD) && ($past(idx) == '0))
    else $error("warm-up flag cleared outside the final warm-up step");

  // a draw that still needs warm-up never goes straight to the generator step
  a_warm_first: assert property (@(posedge clk) disable iff (rst)
    (accept && draw_request && warm_pending && !seed_we) |=> (state == ST_LOAD))
    else $error("draw skipped the pending warm-up");

endmodule

### design/srng_datapath.sv
// Datapath: seed, congruential step, slot select, shuffle table and output register.
module srng_datapath #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           seed_we,
  input  logic [srng_pkg::VALUE_W-1:0]   seed,
  input  srng_pkg::cmd_t                 cmd,
  input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] warm_idx,
  output logic                           out_full,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [srng_pkg::VALUE_W-1:0]   random_value
);

  localparam int unsigned SLOT_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam longint      SlotDiv  = 1 + (longint'(srng_pkg::MODULUS) - 1) / TABLE_SIZE;

  logic [srng_pkg::VALUE_W-1:0] seed_q;
  logic [srng_pkg::VALUE_W-1:0] seed_clean;
  logic [srng_pkg::VALUE_W-1:0] gen;
  logic [srng_pkg::VALUE_W-1:0] last_output;
  logic [srng_pkg::PROD_W-1:0]  prod;
  logic [srng_pkg::VALUE_W:0]   fold_sum;
  logic [srng_pkg::VALUE_W-1:0] fold_val;
  logic [SLOT_W-1:0]            slot;
  logic [SLOT_W-1:0]            slot_calc;
  logic [srng_pkg::VALUE_W-1:0] rdata;
  logic [srng_pkg::VALUE_W-1:0] mem [TABLE_SIZE];
  logic                         mem_we;
  logic [SLOT_W-1:0]            mem_waddr;
  logic [srng_pkg::VALUE_W-1:0] mem_wdata;

  // zero and the modulus itself both map to one
  assign seed_clean = (seed_q == '0 || seed_q == srng_pkg::MODULUS) ?
                      srng_pkg::VALUE_W'(1) : seed_q;

  // 2^31 == 1 mod (2^31 - 1): add the high part back in, one conditional subtract
  assign fold_sum = {1'b0, prod[srng_pkg::VALUE_W-1:0]}
                  + (srng_pkg::VALUE_W+1)'(prod[srng_pkg::PROD_W-1:srng_pkg::VALUE_W]);
  assign fold_val = (fold_sum >= {1'b0, srng_pkg::MODULUS}) ?
                    srng_pkg::VALUE_W'(fold_sum - {1'b0, srng_pkg::MODULUS}) :
                    fold_sum[srng_pkg::VALUE_W-1:0];

  // slot = last_output / SlotDiv via constant thresholds; never exceeds TABLE_SIZE-1
  always_comb begin
    slot_calc = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if (last_output >= srng_pkg::VALUE_W'(longint'(k) * SlotDiv)) begin
        slot_calc = SLOT_W'(k);
      end
    end
  end

  assign mem_we    = cmd.warm_wr || cmd.commit;
  assign mem_waddr = cmd.commit ? slot : warm_idx;
  assign mem_wdata = cmd.commit ? gen : fold_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_q <= '0;
    end else if (seed_we) begin
      seed_q <= seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen         <= '0;
      last_output <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen <= seed_clean;
      end else if (cmd.fold) begin
        gen <= fold_val;
      end
      if (cmd.warm_last) begin
        last_output <= fold_val;
      end else if (cmd.commit) begin
        last_output <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= srng_pkg::PROD_W'(gen) * srng_pkg::PROD_W'(srng_pkg::MULTIPLIER);
    end
    if (cmd.slot_calc) begin
      slot <= slot_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      random_value <= rdata;
    end
  end

  assign out_full = result_valid && result_stall;

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (random_value != '0) && (random_value != srng_pkg::MODULUS))
    else $error("result outside 1 .. modulus-1");

  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.fold) |-> (gen != '0) && (gen != srng_pkg::MODULUS))
    else $error("generator left its residue range");

endmodule

### design/shuffled_minimal_standard_rng_unit.sv
// Top level of the shuffled minimal-standard random number generator.
// Each draw transaction with draw_request high returns one 31-bit value in
// 1 .. 2^31-2 (read as value / (2^31-1)) from a 16807 * x mod (2^31-1)
// generator feeding a TABLE_SIZE-entry Bays-Durham shuffle table. A draw
// passes through accept, the multiply, the modulus fold plus table read,
// then the table write-back and result load, and no new draw is taken until
// it is through; the multiply/fold of the congruential step and the single
// write port of the table set that sequence. The first draw after reset or
// after any seed write runs the warm-up first. A draw transaction with
// draw_request low is taken and produces nothing. The result sits in an
// output register, so a new draw is taken while it waits; the write-back
// stalls until that register frees up. Write the seed only while no draw is
// in flight; zero is read as one.
module shuffled_minimal_standard_rng_unit #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        seed_we,
  input  logic [30:0] seed,
  // draw channel
  input  logic        draw_valid,
  output logic        draw_stall,
  input  logic        draw_request,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [30:0] random_value
);

  localparam int unsigned SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  srng_pkg::cmd_t    cmd;
  logic [SLOT_W-1:0] warm_idx;
  logic              out_full;

  // sequencing: warm-up loop, step, table access, commit
  srng_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .draw_valid   (draw_valid),
    .draw_request (draw_request),
    .draw_stall   (draw_stall),
    .seed_we      (seed_we),
    .out_full     (out_full),
    .cmd          (cmd),
    .warm_idx     (warm_idx)
  );

  // arithmetic, shuffle table and output register
  srng_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .seed         (seed),
    .cmd          (cmd),
    .warm_idx     (warm_idx),
    .out_full     (out_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
  );

endmodule

### dv/tb_shuffled_minimal_standard_rng_unit.sv
// Testbench for the shuffled minimal-standard random number generator unit.
`timescale 1ns / 100ps

module tb_shuffled_minimal_standard_rng_unit;

  // Table size of the block under test and of the predictor below.
  localparam int unsigned TBL_SIZE = 32;
  // Slot pick: the previous output divided by this gives the table slot.
  localparam int unsigned SLOT_DIV = 1 + 32'd2147483646 / TBL_SIZE;
  // Generator steps of a warm-up: TABLE_SIZE + 8, the last TABLE_SIZE fill the table.
  localparam int WARM_STEPS = TBL_SIZE + 8;
  // Idle cycles before a seed write: enough for a warm-up plus a draw,
  // with margin, so the block is surely idle when the seed is written.
  localparam int SETTLE_CYCLES = 2 * WARM_STEPS + 40;
  // Watchdog limit.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 5;
  localparam int DRAWS_PER_PHASE = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seed_we = 1'b0;
  logic [30:0] seed = '0;
  logic        draw_valid = 1'b0;
  logic        draw_stall;
  logic        draw_request = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [30:0] random_value;

  // Predictor state: seed register, generator, previous output, shuffle slots,
  // and the warm-up flag that reset and every seed write arm.
  logic [30:0] model_seed = '0;
  logic [30:0] model_gen = '0;
  logic [30:0] model_last = '0;
  logic [30:0] model_slots [TBL_SIZE];
  logic        model_warm = 1'b1;

  // Values the block still owes us, oldest first.
  logic [30:0] expected_randoms [$];
  logic [30:0] checker_want;

  int errors = 0;
  int cycle_count = 0;
  // quiet: no sender gaps and no receiver stalls other than a hold-off.
  bit quiet = 1'b0;
  // Receiver hold-off, counted down by the stall generator.
  int hold_off_left = 0;

  shuffled_minimal_standard_rng_unit #(
    .TABLE_SIZE(TBL_SIZE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .seed_we     (seed_we),
    .seed        (seed),
    .draw_valid  (draw_valid),
    .draw_stall  (draw_stall),
    .draw_request(draw_request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .random_value(random_value)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One congruential step: x * 16807 mod (2^31 - 1), done in 64 bits.
  function automatic logic [30:0] mcg_step(logic [30:0] x);
    logic [63:0] prod;
    prod = {33'd0, x} * 64'(srng_pkg::MULTIPLIER);
    return 31'(prod % {33'd0, srng_pkg::MODULUS});
  endfunction

  // Advance the predictor by one draw and return the shuffled value.
  function automatic logic [30:0] next_random();
    int j;
    int unsigned slot;
    logic [30:0] s;
    if (model_warm) begin
      // Seed of zero, or the modulus itself (zero mod the modulus), means one.
      s = model_seed;
      if (s == 31'd0 || s == srng_pkg::MODULUS)
        s = 31'd1;
      model_gen = s;
      for (j = WARM_STEPS - 1; j >= 0; j--) begin
        model_gen = mcg_step(model_gen);
        if (j < TBL_SIZE)
          model_slots[j] = model_gen;
      end
      model_last = model_slots[0];
      model_warm = 1'b0;
    end
    model_gen = mcg_step(model_gen);
    slot = model_last / SLOT_DIV;
    if (slot >= TBL_SIZE)
      slot = TBL_SIZE - 1;
    model_last = model_slots[slot];
    model_slots[slot] = model_gen;
    return model_last;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gap: half none, most of the rest short, a few long.
  function automatic int draw_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one draw transaction and wait for the handshake. Called at a rising
  // edge; valid stays high across back-to-back transactions.
  task automatic send_draw(input logic req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      draw_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    draw_valid   <= 1'b1;
    draw_request <= req;
    do
      @(posedge clk);
    while (draw_stall);
    // Accepted at this edge.
    if (req)
      expected_randoms.push_back(next_random());
  endtask

  // Drop valid and move on one edge so a later raise is in a new time step.
  task automatic park_draw();
    draw_valid <= 1'b0;
    @(posedge clk);
  endtask

  // All results in, then enough cycles for any trailing work to finish.
  task automatic wait_idle();
    while (expected_randoms.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Seed write, only with the block idle; re-arms the warm-up.
  task automatic write_seed(input logic [30:0] value);
    park_draw();
    wait_idle();
    seed_we <= 1'b1;
    seed    <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    model_seed = value;
    model_warm = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the seed register is zero, read as one. The first
  // draw runs the warm-up; a draw_request=0 transaction yields nothing.
  task automatic test_reset_seed();
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b1);
  endtask

  // Seed extremes: the modulus value (outside the range, acts like one),
  // the smallest and largest legal seeds, and an explicit zero.
  task automatic test_seed_extremes();
    logic [30:0] seeds [4];
    seeds[0] = srng_pkg::MODULUS;
    seeds[1] = 31'd1;
    seeds[2] = 31'd2147483646;
    seeds[3] = 31'd0;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_draw(1'b1);
      send_draw(1'b1);
    end
  endtask

  // Two writes in a row, then the same seed again: each write re-runs the
  // warm-up, so the sequence restarts.
  task automatic test_rearm();
    write_seed(31'd123456789);
    write_seed(31'd987654321);
    send_draw(1'b1);
    write_seed(31'd987654321);
    send_draw(1'b1);
  endtask

  // No gaps, no stalls: draws at the block's full rate.
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (4) send_draw(1'b1);
    park_draw();
    quiet = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the output register fills and the block stalls its draw input.
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_off_left = 150;
    repeat (8) send_draw(1'b1);
    park_draw();
    quiet = 1'b0;
  endtask

  // Random phases: a new seed per phase (two with alternating bits, the rest
  // random), mostly real draws with some draw_request=0 noise, and a quiet
  // stretch inside each phase.
  task automatic test_random_draws();
    int draws;
    int quiet_from;
    logic [30:0] phase_seed;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_seed = 31'h5555_5555;
        1: phase_seed = 31'h2AAA_AAAA;
        default: phase_seed = 31'($urandom);
      endcase
      write_seed(phase_seed);
      draws = 0;
      quiet_from = $urandom_range(0, DRAWS_PER_PHASE - 20);
      while (draws < DRAWS_PER_PHASE) begin
        quiet = (draws >= quiet_from && draws < quiet_from + 15);
        if ($urandom_range(0, 9) == 0) begin
          send_draw(1'b0);
        end else begin
          send_draw(1'b1);
          draws++;
        end
      end
      quiet = 1'b0;
    end
    park_draw();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall generator: hold-off first, then random runs of stall and
  // no-stall, mostly short, occasionally long.
  // ---------------------------------------------------------------------------
  initial begin : result_stall_gen
    int run;
    logic level;
    run = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        result_stall <= 1'b1;
        hold_off_left--;
      end else if (quiet) begin
        result_stall <= 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          level = ($urandom_range(0, 99) < 40);
          if (!level)
            run = $urandom_range(1, 8);
          else if ($urandom_range(0, 9) == 0)
            run = $urandom_range(10, 40);
          else
            run = $urandom_range(1, 3);
        end
        result_stall <= level;
        run--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result transaction against the oldest
  // expected value.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_randoms.size() == 0) begin
        $display("%0t: unexpected random_value %0d, nothing expected", $time, random_value);
        errors++;
      end else begin
        checker_want = expected_randoms.pop_front();
        if (random_value !== checker_want) begin
          $display("%0t: random_value mismatch: expected %0d, actual %0d",
                   $time, checker_want, random_value);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shuffled_minimal_standard_rng_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_seed();
    test_seed_extremes();
    test_rearm();
    test_back_to_back();
    test_backpressure();
    test_random_draws();

    // Drain, then give a stray result time to show up.
    while (expected_randoms.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_randoms.size() != 0) begin
      $display("%0t: %0d expected random values never arrived", $time,
               expected_randoms.size());
      errors++;
    end
    if (errors == 0)
      $display("shuffled_minimal_standard_rng_unit test passed");
    else
      $display("shuffled_minimal_standard_rng_unit test failed");
    $finish;
  end

endmodule

### files.f
design/srng_pkg.sv
design/srng_ctrl.sv
design/srng_datapath.sv
design/shuffled_minimal_standard_rng_unit.sv
dv/tb_shuffled_minimal_standard_rng_unit.sv
